>>> rtl/apqm_pkg.sv
// Shared types, widths and register codes for the attitude PD controller and X mixer.
// No dependencies; every other file of the block imports this package.
package apqm_pkg;

  // Register file
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned SAFE_W     = 15;

  // Datapath widths
  localparam int unsigned IN_W    = 16;  // stick, angle and gyro words
  localparam int unsigned ERR_W   = 22;  // roll / pitch angle error, 1/4096 deg
  localparam int unsigned EY_W    = 28;  // yaw rate error, 1/32768 dps
  localparam int unsigned PP_W    = 46;  // kp * angle error
  localparam int unsigned PD_W    = 40;  // kd * gyro
  localparam int unsigned PY_W    = 52;  // kp_yaw * yaw error
  localparam int unsigned SUM_W   = 50;  // roll / pitch PD sum before rounding
  localparam int unsigned YSUM_W  = 53;  // yaw product plus rounding bias
  localparam int unsigned RND_W   = 30;  // rounded command before clamping
  localparam int unsigned CMD_W   = 17;  // clamped command, signed Q0.16
  localparam int unsigned MIX_W   = 20;  // throttle plus three commands
  localparam int unsigned MOTOR_W = 16;

  localparam int unsigned PD_SHIFT  = 20;
  localparam int unsigned YAW_SHIFT = 23;

  // Cycles from an accepted input word to its result strobe
  localparam int unsigned LATENCY = 5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_ROLL        = 3'd0,
    REG_KD_ROLL        = 3'd1,
    REG_KP_PITCH       = 3'd2,
    REG_KD_PITCH       = 3'd3,
    REG_KP_YAW_RATE    = 3'd4,
    REG_TILT_CMD_LIMIT = 3'd5,
    REG_YAW_CMD_LIMIT  = 3'd6,
    REG_SAFE_TILT      = 3'd7
  } cfg_idx_e;

  // Reset values
  localparam logic [GAIN_W-1:0] KP_ROLL_RST     = 24'd83886;
  localparam logic [GAIN_W-1:0] KD_ROLL_RST     = 24'd20133;
  localparam logic [GAIN_W-1:0] KP_PITCH_RST    = 24'd83886;
  localparam logic [GAIN_W-1:0] KD_PITCH_RST    = 24'd20133;
  localparam logic [GAIN_W-1:0] KP_YAW_RATE_RST = 24'd25166;
  localparam logic [LIM_W-1:0]  TILT_LIM_RST    = 16'd3932;
  localparam logic [LIM_W-1:0]  YAW_LIM_RST     = 16'd5243;
  localparam logic [SAFE_W-1:0] SAFE_TILT_RST   = 15'd5760;

  // Clamped commands handed to the mixer stage
  typedef struct packed {
    logic                      valid;
    logic                      stop;
    logic [MOTOR_W-1:0]        throttle;
    logic signed [CMD_W-1:0]   roll;
    logic signed [CMD_W-1:0]   pitch;
    logic signed [CMD_W-1:0]   yaw;
  } cmd_t;

endpackage

>>> rtl/attitude_pd_quad_x_mixer_unit.sv
// Attitude PD controller and X-quad mixer, top level: registers, error, multiply,
// round and clamp stages. Depends on apqm_pkg and apqm_mix.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start_i / busy_o   | sticks, throttle, flags, angles, gyro rates
//  result   | done_o (strobe)    | four motor words, stop_motors_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
//  One word is taken every cycle; busy_o stays low.
//  Each result is carried from its start_i through the five register stages
//  (errors, products, rounded sums, clamped commands, mixed motors).
//  Reset clears the stage valid bits and loads the register defaults.
//  done_o is high for one cycle per result and the motor words hold until the next; the pipeline never stalls.
module attitude_pd_quad_x_mixer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [apqm_pkg::IN_W-1:0] roll_stick_i,
  input  logic signed [apqm_pkg::IN_W-1:0] pitch_stick_i,
  input  logic signed [apqm_pkg::IN_W-1:0] yaw_stick_i,
  input  logic [apqm_pkg::MOTOR_W-1:0]     throttle_i,
  input  logic                             rc_valid_i,
  input  logic                             kill_switch_i,
  input  logic                             imu_valid_i,
  input  logic signed [apqm_pkg::IN_W-1:0] roll_angle_i,
  input  logic signed [apqm_pkg::IN_W-1:0] pitch_angle_i,
  input  logic signed [apqm_pkg::IN_W-1:0] gyro_x_i,
  input  logic signed [apqm_pkg::IN_W-1:0] gyro_y_i,
  input  logic signed [apqm_pkg::IN_W-1:0] gyro_z_i,
  // result channel
  output logic                             done_o,
  output logic [apqm_pkg::MOTOR_W-1:0]     motor_right_rear_o,
  output logic [apqm_pkg::MOTOR_W-1:0]     motor_right_front_o,
  output logic [apqm_pkg::MOTOR_W-1:0]     motor_left_rear_o,
  output logic [apqm_pkg::MOTOR_W-1:0]     motor_left_front_o,
  output logic                             stop_motors_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [apqm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [apqm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import apqm_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [GAIN_W-1:0] kp_roll_q, kd_roll_q, kp_pitch_q, kd_pitch_q, kp_yaw_q;
  logic [LIM_W-1:0]  tilt_lim_q, yaw_lim_q;
  logic [SAFE_W-1:0] safe_tilt_q;

  // Write the addressed register, keeping only its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_roll_q   <= KP_ROLL_RST;
      kd_roll_q   <= KD_ROLL_RST;
      kp_pitch_q  <= KP_PITCH_RST;
      kd_pitch_q  <= KD_PITCH_RST;
      kp_yaw_q    <= KP_YAW_RATE_RST;
      tilt_lim_q  <= TILT_LIM_RST;
      yaw_lim_q   <= YAW_LIM_RST;
      safe_tilt_q <= SAFE_TILT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_KP_ROLL:        kp_roll_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_KD_ROLL:        kd_roll_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_KP_PITCH:       kp_pitch_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_KD_PITCH:       kd_pitch_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_KP_YAW_RATE:    kp_yaw_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_TILT_CMD_LIMIT: tilt_lim_q  <= cfg_wdata_i[LIM_W-1:0];
        REG_YAW_CMD_LIMIT:  yaw_lim_q   <= cfg_wdata_i[LIM_W-1:0];
        REG_SAFE_TILT:      safe_tilt_q <= cfg_wdata_i[SAFE_W-1:0];
        default:            kp_roll_q   <= kp_roll_q;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------- stage 1: errors
  logic signed [ERR_W-1:0] er_d, ep_d;
  logic signed [EY_W-1:0]  ey_d;
  logic [IN_W:0]           abs_ra, abs_pa;
  logic                    stop_d;

  assign er_d = -{{(ERR_W-IN_W){roll_stick_i[IN_W-1]}}, roll_stick_i}
                - ({{(ERR_W-IN_W){roll_angle_i[IN_W-1]}}, roll_angle_i} <<< 5);
  assign ep_d =  {{(ERR_W-IN_W){pitch_stick_i[IN_W-1]}}, pitch_stick_i}
                + ({{(ERR_W-IN_W){pitch_angle_i[IN_W-1]}}, pitch_angle_i} <<< 5);
  assign ey_d = ({{(EY_W-IN_W){yaw_stick_i[IN_W-1]}}, yaw_stick_i} * EY_W'(50))
                + ({{(EY_W-IN_W){gyro_z_i[IN_W-1]}}, gyro_z_i} <<< 11);

  // Tilt magnitudes, one bit wider so that the most negative angle fits
  assign abs_ra = roll_angle_i[IN_W-1]
                  ? (IN_W+1)'(-{roll_angle_i[IN_W-1], roll_angle_i})
                  : {1'b0, roll_angle_i};
  assign abs_pa = pitch_angle_i[IN_W-1]
                  ? (IN_W+1)'(-{pitch_angle_i[IN_W-1], pitch_angle_i})
                  : {1'b0, pitch_angle_i};

  assign stop_d = !rc_valid_i || kill_switch_i || !imu_valid_i
                  || (abs_ra > (IN_W+1)'(safe_tilt_q))
                  || (abs_pa > (IN_W+1)'(safe_tilt_q));

  logic                    v1_q;
  logic signed [ERR_W-1:0] er_q, ep_q;
  logic signed [EY_W-1:0]  ey_q;
  logic signed [IN_W-1:0]  gx1_q, gy1_q;
  logic [MOTOR_W-1:0]      thr1_q;
  logic                    stop1_q;

  // -------------------------------------------------------- stage 2: products
  logic signed [PP_W-1:0] pp_roll_d, pp_pitch_d;
  logic signed [PD_W-1:0] pd_roll_d, pd_pitch_d;
  logic signed [PY_W-1:0] py_d;

  assign pp_roll_d  = PP_W'($signed({1'b0, kp_roll_q}))  * PP_W'(er_q);
  assign pp_pitch_d = PP_W'($signed({1'b0, kp_pitch_q})) * PP_W'(ep_q);
  assign pd_roll_d  = PD_W'($signed({1'b0, kd_roll_q}))  * PD_W'(gx1_q);
  assign pd_pitch_d = PD_W'($signed({1'b0, kd_pitch_q})) * PD_W'(gy1_q);
  assign py_d       = PY_W'($signed({1'b0, kp_yaw_q}))   * PY_W'(ey_q);

  logic                   v2_q;
  logic signed [PP_W-1:0] pp_roll_q, pp_pitch_q;
  logic signed [PD_W-1:0] pd_roll_q, pd_pitch_q;
  logic signed [PY_W-1:0] py_q;
  logic [MOTOR_W-1:0]     thr2_q;
  logic                   stop2_q;

  // ------------------------------------------------ stage 3: sum and round
  logic signed [SUM_W-1:0]  sum_roll, sum_pitch;
  logic signed [YSUM_W-1:0] sum_yaw;
  logic signed [RND_W-1:0]  rnd_roll_d, rnd_pitch_d, rnd_yaw_d;

  // Add half an LSB, then drop the fraction: round half up
  assign sum_roll  = {{(SUM_W-PP_W){pp_roll_q[PP_W-1]}}, pp_roll_q}
                     - ({{(SUM_W-PD_W){pd_roll_q[PD_W-1]}}, pd_roll_q} <<< 8)
                     + (SUM_W'(1) << (PD_SHIFT-1));
  assign sum_pitch = {{(SUM_W-PP_W){pp_pitch_q[PP_W-1]}}, pp_pitch_q}
                     + ({{(SUM_W-PD_W){pd_pitch_q[PD_W-1]}}, pd_pitch_q} <<< 8)
                     + (SUM_W'(1) << (PD_SHIFT-1));
  assign sum_yaw   = {{(YSUM_W-PY_W){py_q[PY_W-1]}}, py_q}
                     + (YSUM_W'(1) << (YAW_SHIFT-1));

  assign rnd_roll_d  = sum_roll[SUM_W-1:PD_SHIFT];
  assign rnd_pitch_d = sum_pitch[SUM_W-1:PD_SHIFT];
  assign rnd_yaw_d   = sum_yaw[YSUM_W-1:YAW_SHIFT];

  logic                    v3_q;
  logic signed [RND_W-1:0] rnd_roll_q, rnd_pitch_q, rnd_yaw_q;
  logic [MOTOR_W-1:0]      thr3_q;
  logic                    stop3_q;

  // --------------------------------------------------------- stage 4: clamp
  function automatic logic signed [CMD_W-1:0] clamp_cmd(
    input logic signed [RND_W-1:0] x,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    logic signed [CMD_W-1:0] res;
    hi = $signed({{(RND_W-LIM_W){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      res = hi[CMD_W-1:0];
    end else if (x < lo) begin
      res = lo[CMD_W-1:0];
    end else begin
      res = x[CMD_W-1:0];
    end
    return res;
  endfunction

  cmd_t cmd_d, cmd_q;

  always_comb begin
    cmd_d.valid    = v3_q;
    cmd_d.stop     = stop3_q;
    cmd_d.throttle = thr3_q;
    cmd_d.roll     = clamp_cmd(rnd_roll_q,  tilt_lim_q);
    cmd_d.pitch    = clamp_cmd(rnd_pitch_q, tilt_lim_q);
    cmd_d.yaw      = clamp_cmd(rnd_yaw_q,   yaw_lim_q);
  end

  // Advance the valid bits; load the clamped commands with their valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      cmd_q <= '0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      cmd_q.valid <= cmd_d.valid;
      if (v3_q) begin
        cmd_q.stop     <= cmd_d.stop;
        cmd_q.throttle <= cmd_d.throttle;
        cmd_q.roll     <= cmd_d.roll;
        cmd_q.pitch    <= cmd_d.pitch;
        cmd_q.yaw      <= cmd_d.yaw;
      end
    end
  end

  // Payload registers load with their stage's valid
  always_ff @(posedge clk_i) begin
    if (accept) begin
      er_q    <= er_d;
      ep_q    <= ep_d;
      ey_q    <= ey_d;
      gx1_q   <= gyro_x_i;
      gy1_q   <= gyro_y_i;
      thr1_q  <= throttle_i;
      stop1_q <= stop_d;
    end
    if (v1_q) begin
      pp_roll_q  <= pp_roll_d;
      pp_pitch_q <= pp_pitch_d;
      pd_roll_q  <= pd_roll_d;
      pd_pitch_q <= pd_pitch_d;
      py_q       <= py_d;
      thr2_q     <= thr1_q;
      stop2_q    <= stop1_q;
    end
    if (v2_q) begin
      rnd_roll_q  <= rnd_roll_d;
      rnd_pitch_q <= rnd_pitch_d;
      rnd_yaw_q   <= rnd_yaw_d;
      thr3_q      <= thr2_q;
      stop3_q     <= stop2_q;
    end
  end

  // ---------------------------------------------------------- stage 5: mix
  apqm_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_q),
    .done_o     (done_o),
    .stop_o     (stop_motors_o),
    .motor_rr_o (motor_right_rear_o),
    .motor_rf_o (motor_right_front_o),
    .motor_lr_o (motor_left_rear_o),
    .motor_lf_o (motor_left_front_o)
  );

endmodule

>>> rtl/apqm_mix.sv
// X-frame motor mixer: the last pipeline stage, with registered motor outputs.
// Depends on apqm_pkg (cmd_t and widths).
module apqm_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apqm_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output logic                          stop_o,
  output logic [apqm_pkg::MOTOR_W-1:0]  motor_rr_o,
  output logic [apqm_pkg::MOTOR_W-1:0]  motor_rf_o,
  output logic [apqm_pkg::MOTOR_W-1:0]  motor_lr_o,
  output logic [apqm_pkg::MOTOR_W-1:0]  motor_lf_o
);
  import apqm_pkg::*;

  // Saturate a mixed value to the motor range
  function automatic logic [MOTOR_W-1:0] sat_motor(input logic signed [MIX_W-1:0] m);
    logic [MOTOR_W-1:0] res;
    if (m[MIX_W-1]) begin
      res = '0;
    end else if (|m[MIX_W-2:MOTOR_W]) begin
      res = '1;
    end else begin
      res = m[MOTOR_W-1:0];
    end
    return res;
  endfunction

  logic signed [MIX_W-1:0] thr_x, r_x, p_x, y_x;
  logic signed [MIX_W-1:0] m_rr, m_rf, m_lr, m_lf;
  logic                    done_q;
  logic                    stop_q;
  logic [MOTOR_W-1:0]      rr_q, rf_q, lr_q, lf_q;

  // Extend operands to the mixer width
  assign thr_x = $signed({{(MIX_W-MOTOR_W){1'b0}}, cmd_i.throttle});
  assign r_x   = {{(MIX_W-CMD_W){cmd_i.roll[CMD_W-1]}},  cmd_i.roll};
  assign p_x   = {{(MIX_W-CMD_W){cmd_i.pitch[CMD_W-1]}}, cmd_i.pitch};
  assign y_x   = {{(MIX_W-CMD_W){cmd_i.yaw[CMD_W-1]}},   cmd_i.yaw};

  // X mix
  assign m_rr = thr_x - p_x - r_x + y_x;
  assign m_rf = thr_x + p_x - r_x - y_x;
  assign m_lr = thr_x - p_x + r_x - y_x;
  assign m_lf = thr_x + p_x + r_x + y_x;

  // Strobe for one cycle per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.valid;
    end
  end

  // Load the result only when a word arrives
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid) begin
      stop_q <= cmd_i.stop;
      rr_q   <= sat_motor(m_rr);
      rf_q   <= sat_motor(m_rf);
      lr_q   <= sat_motor(m_lr);
      lf_q   <= sat_motor(m_lf);
    end
  end

  assign done_o     = done_q;
  assign stop_o     = stop_q;
  assign motor_rr_o = rr_q;
  assign motor_rf_o = rf_q;
  assign motor_lr_o = lr_q;
  assign motor_lf_o = lf_q;

endmodule

>>> rtl/apqm_chk.sv
// Port-level checker for the attitude PD mixer, bound to the top level.
// Depends on apqm_pkg (LATENCY).
module apqm_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             rc_valid_i,
  input logic                             kill_switch_i,
  input logic                             imu_valid_i,
  input logic signed [apqm_pkg::IN_W-1:0] roll_angle_i,
  input logic signed [apqm_pkg::IN_W-1:0] pitch_angle_i,
  input logic                             done_o,
  input logic                             stop_motors_o
);
  import apqm_pkg::*;

  // Every accepted word yields a strobe after the pipeline depth
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("accepted word produced no result");

  // No strobe without a word accepted the pipeline depth earlier
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result strobe without an accepted word");

  // Bad link, bad IMU or the kill switch always raises stop
  a_flag_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (kill_switch_i || !rc_valid_i || !imu_valid_i)
    |-> ##LATENCY (done_o && stop_motors_o))
    else $error("stop not raised for a safety flag");

  // Good flags and level attitude never raise stop
  a_level_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && rc_valid_i && !kill_switch_i && imu_valid_i
    && roll_angle_i == '0 && pitch_angle_i == '0
    |-> ##LATENCY (done_o && !stop_motors_o))
    else $error("stop raised for level attitude and good flags");

endmodule

bind attitude_pd_quad_x_mixer_unit apqm_chk u_apqm_chk (.*);
